// ===== src/pc_line_table_encoder_defines.svh =====
// ---------------------------------------------------------------------------
// pc_line_table_encoder_defines.svh
// Assertion macros used by the port checker file of the table encoder.
// ---------------------------------------------------------------------------
`ifndef PC_LINE_TABLE_ENCODER_DEFINES_SVH
`define PC_LINE_TABLE_ENCODER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define PLTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted
`define PLTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs through reset
`define PLTE_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/plte_pkg.sv =====
// ---------------------------------------------------------------------------
// plte_pkg
// Types, codes and constants of the pc/line table encoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plte_pkg;

  // Default parameter values
  localparam int PC_QUANTUM_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Run encoding limits
  localparam int RUN_MAX  = 126;
  localparam int STEP_MAX = 4 * RUN_MAX;
  localparam int RUN_W    = $clog2(STEP_MAX + 1);

  // Command codes
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_ENTRY  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // PC step encoding modes
  localparam logic [1:0] PCM_NONE = 2'd0;
  localparam logic [1:0] PCM_RUN  = 2'd1;
  localparam logic [1:0] PCM_ESC  = 2'd2;

  // Table byte codes
  localparam logic [7:0] RUN_BASE_BYTE  = 8'd128;
  localparam logic [7:0] PC_ESC_BYTE    = 8'd255;
  localparam logic [7:0] PAD_BYTE       = 8'd129;
  localparam logic [7:0] LINE_ESC_BYTE  = 8'd0;
  localparam logic [7:0] LINE_NEG_BASE  = 8'd64;
  localparam int         LINE_SHORT_MAX = 64;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] entry_pc;
    logic [30:0] entry_line;
    logic        skip;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic [31:0] table_bytes;
  } out_item_t;

  // Classified work handed from front to back
  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       pc_mode;
    logic [RUN_W-1:0] run_words;
    logic [31:0]      pc;
    logic             line_long;
    logic [7:0]       line_byte;
    logic [31:0]      line_word;
  } job_t;

endpackage

`default_nettype wire

// ===== src/plte_front.sv =====
// ---------------------------------------------------------------------------
// plte_front
// Accepts items, tracks previous pc and line, classifies pc step and line
// delta, and pushes one job per start, finish or sent entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plte_front #(
  parameter int PC_QUANTUM = plte_pkg::PC_QUANTUM_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire plte_pkg::in_item_t in_data,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata,
  output logic                   job_valid,
  input  wire logic              job_ready,
  output plte_pkg::job_t         job_data
);

  // Divide-by-quantum through a reciprocal, exact below STEP_LIM
  localparam int STEP_LIM = (plte_pkg::STEP_MAX + 1) * PC_QUANTUM;
  localparam int DIV_W    = $clog2(STEP_LIM);
  localparam int SHIFT    = DIV_W + $clog2(PC_QUANTUM);
  localparam int RECIP    = (2 ** SHIFT + PC_QUANTUM - 1) / PC_QUANTUM;
  localparam int RECIP_W  = SHIFT + 1;
  localparam int PROD_W   = DIV_W + RECIP_W;
  localparam logic signed [31:0] NEG_Q = 32'(-PC_QUANTUM);

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_CALC  = 2'd1;
  localparam logic [1:0] F_CLASS = 2'd2;
  localparam logic [1:0] F_PUSH  = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  plte_pkg::in_item_t           item_r;
  logic [31:0]                  text_start_r;
  logic [31:0]                  prev_pc_r;
  logic [30:0]                  prev_line_r;
  logic [31:0]                  diff_r;
  logic [31:0]                  dl_r;
  logic [1:0]                   pc_mode_r, pc_mode_nxt;
  logic [plte_pkg::RUN_W-1:0]   run_words_r;
  logic                         line_long_r, line_long_nxt;
  logic [7:0]                   line_byte_r, line_byte_nxt;
  logic [PROD_W-1:0]            prod;
  logic                         push;

  assign in_ready  = (state_r == F_IDLE);
  assign job_valid = (state_r == F_PUSH);
  assign push      = job_valid && job_ready;

  // Sequence one item through calc and, as its command needs, classify and push
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) state_nxt = F_CALC;
      end
      F_CALC: begin
        case (item_r.cmd)
          plte_pkg::CMD_START,
          plte_pkg::CMD_FINISH: state_nxt = F_PUSH;
          plte_pkg::CMD_ENTRY: begin
            if (item_r.skip || (item_r.entry_line == prev_line_r)) begin
              state_nxt = F_IDLE;
            end else begin
              state_nxt = F_CLASS;
            end
          end
          default: state_nxt = F_IDLE;
        endcase
      end
      F_CLASS: state_nxt = F_PUSH;
      F_PUSH: begin
        if (job_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // Classify the pc step in words
  always_comb begin
    if (diff_r[31]) begin
      pc_mode_nxt = ($signed(diff_r) <= NEG_Q) ? plte_pkg::PCM_ESC : plte_pkg::PCM_NONE;
    end else if (diff_r < 32'(PC_QUANTUM)) begin
      pc_mode_nxt = plte_pkg::PCM_NONE;
    end else if (diff_r < 32'(STEP_LIM)) begin
      pc_mode_nxt = plte_pkg::PCM_RUN;
    end else begin
      pc_mode_nxt = plte_pkg::PCM_ESC;
    end
  end

  assign prod = PROD_W'(diff_r[DIV_W-1:0]) * PROD_W'(RECIP);

  // Classify the line delta
  always_comb begin
    line_long_nxt = ($signed(dl_r) > 32'sd64) || ($signed(dl_r) < -32'sd64);
    line_byte_nxt = dl_r[31] ? (plte_pkg::LINE_NEG_BASE - dl_r[7:0]) : dl_r[7:0];
  end

  // Control state and tracked pc/line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_IDLE;
      text_start_r <= '0;
      prev_pc_r    <= '0;
      prev_line_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) text_start_r <= cfg_wdata;
      if (push) begin
        if (item_r.cmd == plte_pkg::CMD_START) begin
          prev_pc_r   <= text_start_r;
          prev_line_r <= '0;
        end else if (item_r.cmd == plte_pkg::CMD_ENTRY) begin
          prev_pc_r   <= item_r.entry_pc + 32'(PC_QUANTUM);
          prev_line_r <= item_r.entry_line;
        end
      end
    end
  end

  // Payload pipeline registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
    if (state_r == F_CALC) begin
      diff_r <= item_r.entry_pc - prev_pc_r;
      dl_r   <= {1'b0, item_r.entry_line} - {1'b0, prev_line_r};
    end
    if (state_r == F_CLASS) begin
      pc_mode_r   <= pc_mode_nxt;
      run_words_r <= prod[SHIFT +: plte_pkg::RUN_W];
      line_long_r <= line_long_nxt;
      line_byte_r <= line_byte_nxt;
    end
  end

  // Assemble the job
  always_comb begin
    job_data           = '0;
    job_data.kind      = item_r.cmd;
    job_data.pc_mode   = pc_mode_r;
    job_data.run_words = run_words_r;
    job_data.pc        = item_r.entry_pc;
    job_data.line_long = line_long_r;
    job_data.line_byte = line_byte_r;
    job_data.line_word = dl_r;
  end

endmodule

`default_nettype wire

// ===== src/plte_fifo.sv =====
// ---------------------------------------------------------------------------
// plte_fifo
// Short job queue between front and back. The oldest job sits in a head
// register that is refilled from the store or straight from the push side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plte_fifo #(
  parameter int DEPTH = plte_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire plte_pkg::job_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output plte_pkg::job_t      pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  plte_pkg::job_t     mem_r [DEPTH];
  plte_pkg::job_t     head_r;
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop, head_free, mem_any, bypass;

  // count_r holds every queued job, the head included
  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = head_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign head_free  = !pop_valid || do_pop;
  assign mem_any    = (count_r > CNT_W'(1));
  assign bypass     = do_push && head_free && !mem_any;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push && !bypass) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (head_free && mem_any) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Store entries and refill the head
  always_ff @(posedge clk) begin
    if (do_push && !bypass) mem_r[wr_ptr_r] <= push_data;
    if (head_free && mem_any) begin
      head_r <= mem_r[rd_ptr_r];
    end else if (bypass) begin
      head_r <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/plte_back.sv =====
// ---------------------------------------------------------------------------
// plte_back
// Executes jobs: emits run, escape, line and pad bytes one per cycle, unless the
// output stalls, into the output register and keeps the saturating byte count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plte_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  output logic                job_ready,
  input  wire plte_pkg::job_t job_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output plte_pkg::out_item_t out_data
);

  localparam int RW = plte_pkg::RUN_W;

  localparam logic [2:0] B_IDLE      = 3'd0;
  localparam logic [2:0] B_RUN       = 3'd1;
  localparam logic [2:0] B_ESC_HEAD  = 3'd2;
  localparam logic [2:0] B_ESC_WORD  = 3'd3;
  localparam logic [2:0] B_LINE_HEAD = 3'd4;
  localparam logic [2:0] B_LINE_WORD = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic [RW-1:0]       runs_r, runs_nxt;
  logic [RW-1:0]       step;
  plte_pkg::job_t      job_r;
  logic [31:0]         byte_count_r, count_inc;
  logic                out_valid_r;
  plte_pkg::out_item_t out_data_r;
  logic                adv, emit, emit_last, clr_count, load;
  logic [7:0]          emit_byte;

  // Big-endian byte of a word
  function automatic logic [7:0] byte_sel(input logic [31:0] w, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  assign adv       = !out_valid_r || out_ready;
  assign count_inc = (byte_count_r == '1) ? byte_count_r : byte_count_r + 32'd1;
  assign step      = (runs_r > RW'(plte_pkg::RUN_MAX)) ? RW'(plte_pkg::RUN_MAX) : runs_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Byte sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    runs_nxt  = runs_r;
    emit      = 1'b0;
    emit_byte = '0;
    emit_last = 1'b0;
    clr_count = 1'b0;
    load      = 1'b0;
    job_ready = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          case (job_data.kind)
            plte_pkg::CMD_START: begin
              job_ready = 1'b1;
              clr_count = 1'b1;
            end
            plte_pkg::CMD_FINISH: begin
              if (byte_count_r[0] && (byte_count_r != '1)) begin
                if (adv) begin
                  job_ready = 1'b1;
                  emit      = 1'b1;
                  emit_byte = plte_pkg::PAD_BYTE;
                  emit_last = 1'b1;
                end
              end else begin
                job_ready = 1'b1;
              end
            end
            plte_pkg::CMD_ENTRY: begin
              job_ready = 1'b1;
              load      = 1'b1;
              runs_nxt  = job_data.run_words;
              case (job_data.pc_mode)
                plte_pkg::PCM_RUN: state_nxt = B_RUN;
                plte_pkg::PCM_ESC: state_nxt = B_ESC_HEAD;
                default:           state_nxt = B_LINE_HEAD;
              endcase
            end
            default: job_ready = 1'b1;
          endcase
        end
      end
      B_RUN: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = plte_pkg::RUN_BASE_BYTE + 8'(step);
          runs_nxt  = runs_r - step;
          if (runs_r == step) state_nxt = B_LINE_HEAD;
        end
      end
      B_ESC_HEAD: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = plte_pkg::PC_ESC_BYTE;
          idx_nxt   = '0;
          state_nxt = B_ESC_WORD;
        end
      end
      B_ESC_WORD: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = byte_sel(job_r.pc, idx_r);
          idx_nxt   = idx_r + 2'd1;
          if (idx_r == 2'd3) state_nxt = B_LINE_HEAD;
        end
      end
      B_LINE_HEAD: begin
        if (adv) begin
          emit = 1'b1;
          if (job_r.line_long) begin
            emit_byte = plte_pkg::LINE_ESC_BYTE;
            idx_nxt   = '0;
            state_nxt = B_LINE_WORD;
          end else begin
            emit_byte = job_r.line_byte;
            emit_last = 1'b1;
            state_nxt = B_IDLE;
          end
        end
      end
      B_LINE_WORD: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = byte_sel(job_r.line_word, idx_r);
          emit_last = (idx_r == 2'd3);
          idx_nxt   = idx_r + 2'd1;
          if (idx_r == 2'd3) state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control state, count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      byte_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_count) begin
        byte_count_r <= '0;
      end else if (emit) begin
        byte_count_r <= count_inc;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    runs_r <= runs_nxt;
    if (load) job_r <= job_data;
    if (emit) begin
      out_data_r.out_byte    <= emit_byte;
      out_data_r.last_of_run <= emit_last;
      out_data_r.table_bytes <= count_inc;
    end
  end

endmodule

`default_nettype wire

// ===== src/pc_line_table_encoder.sv =====
// The front takes one item at a time: accept, diff, classify and queue push for a
// sent entry; a start or finish skips classify, and a skipped entry ends after the
// diff. The back emits one byte per cycle unless the output stalls, plus a load
// step per entry, so long byte runs set the rate once the 4-entry job queue fills.
// Reset (rst_n low, synchronous): pc, line, byte count, text_start cleared.
// ---------------------------------------------------------------------------
// pc_line_table_encoder
// Delta-encodes (pc, line) entries into a pc/line table byte stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pc_line_table_encoder #(
  parameter int PC_QUANTUM  = plte_pkg::PC_QUANTUM_DEF,
  parameter int QUEUE_DEPTH = plte_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire plte_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output plte_pkg::out_item_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata
);

  logic           push_valid, push_ready, pop_valid, pop_ready;
  plte_pkg::job_t push_data, pop_data;

  // Classify items
  plte_front #(
    .PC_QUANTUM(PC_QUANTUM)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job_data  (push_data)
  );

  // Decouple front and back
  plte_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Emit bytes
  plte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/plte_checker.sv =====
// ---------------------------------------------------------------------------
// plte_checker
// Port-level checks of the table encoder, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pc_line_table_encoder_defines.svh"

module plte_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire plte_pkg::out_item_t out_data
);

  // Hold a stalled result
  `PLTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // Drop ready after a transfer while the item is worked on
  `PLTE_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready, "input ready right after transfer")

  // Count includes the byte shown
  `PLTE_ASSERT_NOW(a_count_nz, out_valid, out_data.table_bytes != 32'd0, "zero byte count on result")

  // Come out of reset with no result
  `PLTE_ASSERT_NEXT_RST(a_rst_idle, !rst_n, !out_valid, "result valid after reset")

endmodule

bind pc_line_table_encoder plte_checker u_checker (.*);

`default_nettype wire

// ===== verif/plte_stream_checker.sv =====
// ---------------------------------------------------------------------------
// plte_stream_checker
// Watches the item, table byte and text_start ports of the pc/line table
// encoder. It keeps its own copy of the encoder state, expands every item
// transfer into the table bytes it must cause, and compares each byte
// transfer field by field with the oldest byte still owed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module plte_stream_checker
  import plte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          mismatches,
  output int          bytes_due,
  output int          bytes_checked
);

  localparam int          MAX_RUN_BYTES = 10;
  localparam logic [31:0] COUNT_SAT     = 32'hFFFF_FFFF;

  // Mirror of the encoder state
  logic [31:0] text_start;
  logic [31:0] prev_pc;
  logic [31:0] prev_line;
  logic [31:0] byte_count;

  // Table bytes owed by the encoder, oldest first
  out_item_t   owed_bytes[$];
  out_item_t   run_buf[MAX_RUN_BYTES];
  int          run_len;
  int          err_total;
  int          seen_total;

  // Count one table byte and stage it for the current item
  task automatic stage_byte(input logic [7:0] value);
    out_item_t b;
    if (byte_count != COUNT_SAT) begin
      byte_count = byte_count + 1;
    end
    b.out_byte    = value;
    b.last_of_run = 1'b0;
    b.table_bytes = byte_count;
    run_buf[run_len] = b;
    run_len++;
  endtask

  // Stage a 32-bit word, most significant byte first
  task automatic stage_word(input logic [31:0] w);
    stage_byte(w[31:24]);
    stage_byte(w[23:16]);
    stage_byte(w[15:8]);
    stage_byte(w[7:0]);
  endtask

  // Work out the table bytes that one item causes and queue them
  task automatic encode_item(input in_item_t it);
    logic [31:0] pc_gap;
    int          gap_words;
    int          chunk;
    longint      line_delta;
    run_len = 0;
    case (it.cmd)
      CMD_START: begin
        prev_pc    = text_start;
        prev_line  = '0;
        byte_count = '0;
      end
      CMD_FINISH: begin
        // pad to an even length unless the count has saturated
        if (byte_count[0] && byte_count != COUNT_SAT) begin
          stage_byte(PAD_BYTE);
        end
      end
      CMD_ENTRY: begin
        if (!it.skip && {1'b0, it.entry_line} != prev_line) begin
          // pc step in words, truncated toward zero
          pc_gap    = it.entry_pc - prev_pc;
          gap_words = $signed(pc_gap) / PC_QUANTUM_DEF;
          while (gap_words != 0) begin
            if (gap_words < 0 || gap_words > STEP_MAX) begin
              stage_byte(PC_ESC_BYTE);
              stage_word(it.entry_pc);
              gap_words = 0;
            end else begin
              chunk = (gap_words < RUN_MAX) ? gap_words : RUN_MAX;
              stage_byte(RUN_BASE_BYTE + chunk[7:0]);
              gap_words = gap_words - chunk;
            end
          end
          line_delta = longint'(it.entry_line) - longint'(prev_line);
          prev_line  = {1'b0, it.entry_line};
          prev_pc    = it.entry_pc + PC_QUANTUM_DEF;
          if (line_delta > LINE_SHORT_MAX || line_delta < -LINE_SHORT_MAX) begin
            stage_byte(LINE_ESC_BYTE);
            stage_word(line_delta[31:0]);
          end else if (line_delta > 0) begin
            stage_byte(line_delta[7:0]);
          end else begin
            stage_byte(LINE_NEG_BASE - line_delta[7:0]);
          end
        end
      end
      default: begin
        // unused command code: no effect
      end
    endcase
    if (run_len > 0) begin
      run_buf[run_len - 1].last_of_run = 1'b1;
    end
    for (int i = 0; i < run_len; i++) begin
      owed_bytes.push_back(run_buf[i]);
    end
  endtask

  // Compare one byte transfer with the oldest byte owed
  task automatic check_byte(input out_item_t got);
    out_item_t want;
    if (owed_bytes.size() == 0) begin
      err_total++;
      $display("%0t: unexpected byte: expected none, actual byte %0d last %0b count %0d",
               $time, got.out_byte, got.last_of_run, got.table_bytes);
    end else begin
      want = owed_bytes.pop_front();
      seen_total++;
      if (got.out_byte !== want.out_byte) begin
        err_total++;
        $display("%0t: out_byte mismatch: expected %0d actual %0d",
                 $time, want.out_byte, got.out_byte);
      end
      if (got.last_of_run !== want.last_of_run) begin
        err_total++;
        $display("%0t: last_of_run mismatch: expected %0b actual %0b",
                 $time, want.last_of_run, got.last_of_run);
      end
      if (got.table_bytes !== want.table_bytes) begin
        err_total++;
        $display("%0t: table_bytes mismatch: expected %0d actual %0d",
                 $time, want.table_bytes, got.table_bytes);
      end
    end
  endtask

  // Track reset, register writes and both channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      text_start = '0;
      prev_pc    = '0;
      prev_line  = '0;
      byte_count = '0;
      owed_bytes.delete();
    end else begin
      if (out_valid && out_ready) begin
        check_byte(out_data);
      end
      if (cfg_we) begin
        text_start = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        encode_item(in_data);
      end
    end
    mismatches    <= err_total;
    bytes_due     <= owed_bytes.size();
    bytes_checked <= seen_total;
  end

endmodule

// ===== verif/pc_line_table_encoder_tb.sv =====
// ---------------------------------------------------------------------------
// pc_line_table_encoder_tb
// Drives start, entry and finish items into the pc/line table encoder:
// a directed sweep of step and line-delta boundaries, then random walks of
// entries under several text_start values and idle/stall patterns,
// including one long output hold-off. A separate checker predicts and
// compares every table byte; this module only makes stimulus and reports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pc_line_table_encoder_tb;
  import plte_pkg::*;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         QUIET_LIMIT   = 4000;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         PHASE_ITEMS   = 95;
  localparam int         NUM_PHASES    = 5;
  localparam int         W             = PC_QUANTUM_DEF;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;

  int          mismatches;
  int          bytes_due;
  int          bytes_checked;

  int          idle_pct     = 0;
  int          stall_pct    = 0;
  logic        hold_req     = 1'b0;
  logic        hold_done    = 1'b0;
  int          hold_left    = 0;
  int          quiet_cycles = 0;
  int          items_sent   = 0;

  // Where the encoder's pc and line should be, to shape well-formed walks
  logic [31:0] gen_pc   = '0;
  logic [30:0] gen_line = '0;
  logic [31:0] cur_text_start = '0;

  pc_line_table_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  plte_stream_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .bytes_due     (bytes_due),
    .bytes_checked (bytes_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("pc_line_table_encoder test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, with a random gap first, and hold it until transfer
  task automatic send_item(input in_item_t it);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Command item with random filler in the unused fields
  task automatic send_cmd(input logic [1:0] cmd);
    in_item_t    it;
    logic [31:0] r;
    r           = $urandom();
    it.cmd        = cmd;
    it.entry_pc   = $urandom();
    it.entry_line = r[30:0];
    it.skip       = r[31];
    if (cmd == CMD_START) begin
      gen_pc   = cur_text_start;
      gen_line = '0;
    end
    send_item(it);
  endtask

  task automatic send_entry(input logic [31:0] pc, input logic [30:0] line,
                            input logic skip);
    in_item_t it;
    it.cmd        = CMD_ENTRY;
    it.entry_pc   = pc;
    it.entry_line = line;
    it.skip       = skip;
    if (!skip && line != gen_line) begin
      gen_pc   = pc + W;
      gen_line = line;
    end
    send_item(it);
  endtask

  // Mostly short forward steps and small line moves, some escapes and noise
  task automatic send_random_entry();
    int          pick;
    logic [31:0] pc;
    longint      ln;
    logic [31:0] r;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      pc = gen_pc + W * $urandom_range(0, 8);
    end else if (pick < 75) begin
      pc = gen_pc + W * $urandom_range(120, 520);
    end else if (pick < 85) begin
      pc = gen_pc - W * $urandom_range(1, 40);
    end else if (pick < 92) begin
      pc = gen_pc + $urandom_range(0, W - 1);
    end else begin
      pc = $urandom();
    end
    ln   = gen_line;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      ln = $urandom_range(0, 1) ? ln + $urandom_range(1, 10) : ln - $urandom_range(1, 10);
    end else if (pick < 75) begin
      ln = $urandom_range(0, 1) ? ln + $urandom_range(63, 66) : ln - $urandom_range(63, 66);
    end else if (pick >= 85) begin
      r  = $urandom();
      ln = r[30:0];
    end
    send_entry(pc, ln[30:0], $urandom_range(0, 11) == 0);
  endtask

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 84) begin
      send_random_entry();
    end else if (pick < 92) begin
      send_cmd(CMD_FINISH);
    end else if (pick < 96) begin
      send_cmd(CMD_START);
    end else begin
      send_cmd(CMD_UNUSED);
    end
  endtask

  // Drop valid, wait for every owed byte, then let trailing work settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (bytes_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_text_start(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_text_start = value;
  endtask

  initial begin
    logic [31:0] base;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_text_start(32'h0000_1000);

    // Directed: step and line-delta boundaries, skips, padding, unused code
    send_entry(32'h0000_0010, 31'd5, 1'b0);          // before any start
    send_cmd(CMD_START);
    send_entry(32'h0000_1000, 31'd1, 1'b0);          // zero pc step
    send_entry(gen_pc + W, 31'd65, 1'b0);            // one word, line +64
    send_entry(gen_pc + 126 * W, 31'd130, 1'b0);     // full run, line +65
    send_entry(gen_pc + 127 * W, 31'd129, 1'b0);     // two runs, line -1
    send_entry(gen_pc + 504 * W, 31'd65, 1'b0);      // longest run, line -64
    send_entry(gen_pc + 505 * W, 31'd0, 1'b0);       // pc escape, line -65
    send_entry(gen_pc - 2 * W, 31'h7FFF_FFFF, 1'b0); // backward step, top line
    send_entry(gen_pc + W, 31'h7FFF_FFFF, 1'b0);     // same line
    send_entry(gen_pc + W, 31'd7, 1'b1);             // skip flag
    send_entry(gen_pc + W - 1, 31'h7FFF_FFFE, 1'b0); // sub-word step
    send_entry(gen_pc - W + 1, 31'd1, 1'b0);         // small backward, big drop
    send_entry(32'hFFFF_FFFF, 31'd2, 1'b0);          // top pc
    send_entry(32'h0000_0000, 31'd3, 1'b0);          // wrap to zero
    send_cmd(CMD_FINISH);
    send_entry(gen_pc, 31'd4, 1'b0);
    send_cmd(CMD_FINISH);
    send_cmd(CMD_FINISH);
    send_cmd(CMD_UNUSED);
    wait_drained();

    // Random walks, one text_start value and idle pattern per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin base = 32'h0000_0000; idle_pct = 0;  stall_pct <= 0;  end
        1: begin base = 32'hFFFF_FFFF; idle_pct = 48; stall_pct <= 0;  end
        2: begin base = $urandom();    idle_pct = 0;  stall_pct <= 48; end
        3: begin base = 32'hFFFF_FFFC; idle_pct = 35; stall_pct <= 35; end
        default: begin
          // long output hold-off while the sender keeps offering
          base = 32'h0040_0000; idle_pct = 0; stall_pct <= 0;
          hold_req <= 1'b1;
        end
      endcase
      write_text_start(base);
      send_cmd(CMD_START);
      repeat (PHASE_ITEMS) send_random_item();
      send_cmd(CMD_FINISH);
      wait_drained();
    end

    $display("covered %0d item transfers and %0d checked table bytes", items_sent,
             bytes_checked);
    $display("over six text_start values, four idle patterns and one long hold-off");
    if (mismatches == 0) begin
      $display("pc_line_table_encoder test passed");
    end else begin
      $display("pc_line_table_encoder test failed");
    end
    $finish;
  end

endmodule
